>>> rtl/sks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sks_pkg: shared types and constants of the k-smallest summing block
// Field widths, the control bundle that drives the cell chain and the
// controller state encoding.
// ----------------------------------------------------------------------------
package sks_pkg;

	// Widths fixed by the interface.
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 7;
	localparam int SUM_W   = 38;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic        [COUNT_W-1:0] count_t;
	typedef logic signed [SUM_W-1:0]   sum_t;

	// Controller states, one-hot.
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SUM  = 2'b10
	} state_t;

	// Broadcast control for every cell of the chain.
	typedef struct packed {
		logic   ins_en;   // insert the broadcast value this cycle
		logic   shift_en; // move every entry one cell toward the head
		logic   clear;    // drop every entry
		value_t value;    // value being inserted
	} cell_ctrl_t;

endpackage

>>> rtl/sks_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sks_cell: one entry of the sorted chain
// Holds a value and a valid flag. On insert it keeps its entry, takes the
// new value, or takes its lower neighbor's entry, so the chain stays in
// ascending order. On shift it takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
module sks_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  sks_pkg::cell_ctrl_t ctrl,
	input  logic                prev_valid,
	input  logic                prev_gt,
	input  sks_pkg::value_t     prev_value,
	input  logic                next_valid,
	input  sks_pkg::value_t     next_value,
	output logic                valid,
	output logic                gt,
	output sks_pkg::value_t     value
);
	import sks_pkg::*;

	logic   valid_q;
	value_t value_q;

	// This entry is larger than the value being inserted.
	assign gt    = valid_q && (ctrl.value < value_q);
	assign valid = valid_q;
	assign value = value_q;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift_en) begin
			valid_q <= next_valid;
		end else if (ctrl.ins_en) begin
			if (prev_gt || (prev_valid && !valid_q)) begin
				valid_q <= 1'b1;
			end
		end
	end

	// Stored value.
	always_ff @(posedge clk) begin
		if (ctrl.shift_en) begin
			value_q <= next_value;
		end else if (ctrl.ins_en) begin
			if (prev_gt) begin
				value_q <= prev_value;
			end else if (prev_valid && (gt || !valid_q)) begin
				value_q <= ctrl.value;
			end
		end
	end

endmodule

>>> rtl/sum_of_k_smallest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sum_of_k_smallest: sum of the k smallest values of a data set
// Keeps the smallest values of a set in a sorted cell chain and adds the
// k smallest of them when the last item of the set arrives.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, value_in, is_last): one signed value
//   per item, is_last marks the final item of a set. While a set streams in,
//   one item is accepted every cycle; each item is inserted in order into a
//   chain of MAX_KEEP cells, and once the chain is full the largest entry
//   falls off the end.
//   After the last item is accepted, the head of the chain is added and the
//   chain shifted once per cycle until min(k, items kept) values are summed;
//   then the sum is loaded into the output register. in_stall is high during
//   that time.
//   Output channel (out_valid, out_stall, smallest_sum): one item per set.
//   The result waits in the output register while out_stall is high; the
//   next set streams in meanwhile, and its summing holds at the end until
//   the register is free.
//   Configuration (cfg_valid, cfg_ready, count_to_sum): k, written between
//   sets; values above MAX_KEEP act as MAX_KEEP.
//   Reset empties the chain, clears k and drops any pending result.
// ----------------------------------------------------------------------------
module sum_of_k_smallest #(
	parameter int MAX_KEEP = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sks_pkg::value_t     value_in,
	input  logic                is_last,
	output logic                out_valid,
	input  logic                out_stall,
	output sks_pkg::sum_t       smallest_sum,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  sks_pkg::count_t     count_to_sum
);
	import sks_pkg::*;

	localparam int CNT_W = $clog2(MAX_KEEP + 1);
	localparam int KW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
	localparam logic [KW-1:0] MAX_K = KW'(MAX_KEEP);

	state_t     state_q;
	count_t     k_q;
	logic [CNT_W-1:0] cnt_q;
	sum_t       acc_q;
	logic       out_valid_q;
	sum_t       out_sum_q;
	cell_ctrl_t ctrl;

	logic        c_valid [MAX_KEEP];
	logic        c_gt    [MAX_KEEP];
	value_t      c_value [MAX_KEEP];

	logic        in_acc;
	logic [KW-1:0] k_ext;
	logic [KW-1:0] k_eff;
	logic        more;
	logic        out_free;

	// Configuration register, always ready.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cfg_valid) begin
			k_q <= count_to_sum;
		end
	end

	// Handshake and summing decisions.
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign k_ext    = KW'(k_q);
	assign k_eff    = (k_ext > MAX_K) ? MAX_K : k_ext;
	assign more     = c_valid[0] && (KW'(cnt_q) < k_eff);
	assign out_free = !out_valid_q || !out_stall;

	// Chain control.
	always_comb begin
		ctrl.value    = value_in;
		ctrl.ins_en   = in_acc;
		ctrl.shift_en = (state_q == ST_SUM) && more;
		ctrl.clear    = (state_q == ST_SUM) && !more && out_free;
	end

	// Sorted cell chain.
	for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
		logic   p_valid;
		logic   p_gt;
		value_t p_value;
		logic   n_valid;
		value_t n_value;

		if (i == 0) begin : g_head
			assign p_valid = 1'b1;
			assign p_gt    = 1'b0;
			assign p_value = value_in;
		end else begin : g_body
			assign p_valid = c_valid[i-1];
			assign p_gt    = c_gt[i-1];
			assign p_value = c_value[i-1];
		end

		if (i == MAX_KEEP - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_value = '0;
		end else begin : g_mid
			assign n_valid = c_valid[i+1];
			assign n_value = c_value[i+1];
		end

		sks_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_valid (p_valid),
			.prev_gt    (p_gt),
			.prev_value (p_value),
			.next_valid (n_valid),
			.next_value (n_value),
			.valid      (c_valid[i]),
			.gt         (c_gt[i]),
			.value      (c_value[i])
		);
	end

	// Controller state and summing count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_acc && is_last) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (more) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Accumulator, fed from the head of the chain.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			acc_q <= '0;
		end else if (more) begin
			acc_q <= acc_q + SUM_W'(c_value[0]);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			out_sum_q <= acc_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign smallest_sum = out_sum_q;

endmodule

>>> rtl/sks_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sks_checker: port-level checks of the k-smallest summing block
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module sks_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input logic          is_last,
	input logic          out_valid,
	input logic          out_stall,
	input sks_pkg::sum_t smallest_sum
);
	import sks_pkg::*;

	// A stalled result stays and keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(smallest_sum))
		else $error("stalled result changed or vanished");

	// Accepting the last item of a set starts the summing phase.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && is_last |=> in_stall)
		else $error("input not held off after last item");

	// A new result only appears at the end of a summing phase.
	a_result_after_sum: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared outside a summing phase");

endmodule

bind sum_of_k_smallest sks_checker u_sks_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.is_last      (is_last),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.smallest_sum (smallest_sum)
);

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the k-smallest summing block
// A queue-fed driver streams data sets into the block while a receiver
// stalls at random and compares every sum with the one worked out by an
// in-bench sorted-store predictor. The count k is changed between phases,
// its extremes included.
// ----------------------------------------------------------------------------
module tb;
	import sks_pkg::*;

	localparam int     MAX_KEEP    = 64;
	localparam int     CYCLE_LIMIT = 400000;
	localparam int     PHASE_ITEMS = 30;
	localparam value_t VALUE_MIN   = 32'sh8000_0000;
	localparam value_t VALUE_MAX   = 32'sh7fff_ffff;

	// How the values of one generated set are chosen.
	typedef enum int {
		MIX_RANDOM,
		MIX_NARROW,
		MIX_EXTREME,
		MIX_ALL_MIN,
		MIX_ALL_MAX,
		MIX_FALLING,
		MIX_RISING
	} mix_t;

	typedef struct packed {
		value_t value;
		logic   last;
	} item_t;

	logic   clk          = 1'b0;
	logic   arst_n       = 1'b0;
	logic   in_valid     = 1'b0;
	value_t value_in     = '0;
	logic   is_last      = 1'b0;
	logic   out_stall    = 1'b0;
	logic   cfg_valid    = 1'b0;
	count_t count_to_sum = '0;
	logic   in_stall;
	logic   out_valid;
	logic   cfg_ready;
	sum_t   smallest_sum;

	item_t  pending_items[$];
	sum_t   expected_sums[$];

	// Predictor state: the smallest values of the current set, ascending.
	value_t kept_values[MAX_KEEP];
	int     kept_count = 0;
	count_t k_setting  = '0;

	int errors       = 0;
	int cycles       = 0;
	int items_queued = 0;
	int tx_gap       = 0;
	int rx_gap       = 0;
	int rx_hold      = 0;
	bit idle_on      = 1'b1;
	bit rx_hold_req  = 1'b0;

	sum_of_k_smallest #(
		.MAX_KEEP(MAX_KEEP)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.value_in    (value_in),
		.is_last     (is_last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.smallest_sum(smallest_sum),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.count_to_sum(count_to_sum)
	);

	always #5 clk = ~clk;

	// Gap length: mostly short, now and then long.
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Insert a value into the sorted store; a full store drops its largest.
	function automatic void keep_smallest(value_t v);
		int pos;
		if (kept_count >= MAX_KEEP) begin
			if (v >= kept_values[MAX_KEEP-1])
				return;
			kept_count = MAX_KEEP - 1;
		end
		pos = kept_count;
		while (pos > 0 && kept_values[pos-1] > v) begin
			kept_values[pos] = kept_values[pos-1];
			pos--;
		end
		kept_values[pos] = v;
		kept_count++;
	endfunction

	// Sum the k smallest kept values and empty the store for the next set.
	function automatic sum_t close_set_sum();
		int     n;
		longint total;
		n = k_setting;
		if (n > MAX_KEEP)
			n = MAX_KEEP;
		if (n > kept_count)
			n = kept_count;
		total = 0;
		for (int i = 0; i < n; i++)
			total += longint'(kept_values[i]);
		kept_count = 0;
		return total[SUM_W-1:0];
	endfunction

	function automatic value_t draw_value(mix_t mix, int idx, value_t base);
		case (mix)
			MIX_RANDOM:  return value_t'($urandom);
			MIX_NARROW:  return value_t'(int'($urandom_range(0, 20)) - 10);
			MIX_EXTREME: begin
				case ($urandom_range(0, 4))
					0:       return VALUE_MIN;
					1:       return VALUE_MAX;
					2:       return -1;
					3:       return 0;
					default: return 1;
				endcase
			end
			MIX_ALL_MIN: return VALUE_MIN;
			MIX_ALL_MAX: return VALUE_MAX;
			MIX_FALLING: return base - value_t'(idx * 3);
			default:     return base + value_t'(idx * 3);
		endcase
	endfunction

	task automatic add_item(value_t v, bit last);
		item_t it;
		it.value = v;
		it.last  = last;
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic queue_set(int size, mix_t mix);
		value_t base;
		base = value_t'($urandom);
		for (int i = 0; i < size; i++)
			add_item(draw_value(mix, i, base), i == size - 1);
	endtask

	// Wait until every item is in and every sum is out, then let the block settle.
	task automatic wait_drained();
		while (pending_items.size() > 0 || in_valid || expected_sums.size() > 0)
			@(posedge clk);
		repeat (MAX_KEEP + 8) @(posedge clk);
	endtask

	// Write k while the block is idle.
	task automatic write_k(count_t k);
		wait_drained();
		@(posedge clk);
		cfg_valid    <= 1'b1;
		count_to_sum <= k;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		k_setting  = k;
	endtask

	// One random phase: a new k, then sets of random size and content.
	task automatic run_phase(count_t k, bit quiet, bit long_hold);
		int   start;
		int   size;
		int   r;
		write_k(k);
		idle_on = !quiet;
		if (long_hold)
			rx_hold_req = 1'b1;
		start = items_queued;
		while (items_queued - start < PHASE_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 65)
				size = $urandom_range(1, 10);
			else if (r < 88)
				size = $urandom_range(11, 40);
			else
				size = $urandom_range(61, 90);
			queue_set(size, mix_t'($urandom_range(0, 6)));
		end
	endtask

	// Input side: record each accepted item, then offer the next one.
	always @(posedge clk) begin : sender
		item_t next_item;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				keep_smallest(value_in);
				if (is_last)
					expected_sums.push_back(close_set_sum());
			end
			if (!in_valid || !in_stall) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					next_item = pending_items.pop_front();
					in_valid <= 1'b1;
					value_in <= next_item.value;
					is_last  <= next_item.last;
					if (idle_on && $urandom_range(0, 99) < 30)
						tx_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output side: check each accepted sum, then choose the next stall.
	always @(posedge clk) begin : receiver
		sum_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_sums.size() == 0) begin
					errors++;
					$display("%0t: smallest_sum expected none, actual %0d", $time,
						smallest_sum);
				end else begin
					want = expected_sums.pop_front();
					if (smallest_sum !== want) begin
						errors++;
						$display("%0t: smallest_sum expected %0d, actual %0d", $time,
							want, smallest_sum);
					end
				end
			end
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				rx_hold     = 300;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				out_stall <= 1'b1;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (idle_on && $urandom_range(0, 99) < 25)
					rx_gap = pick_gap();
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d sums outstanding", $time, expected_sums.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed sets: k zero, k above the set size and above the store,
		// single-item sets, duplicates and the value extremes.
		write_k(0);
		add_item(5, 0);
		add_item(-3, 0);
		add_item(7, 1);
		write_k(127);
		add_item(VALUE_MAX, 0);
		add_item(VALUE_MIN, 0);
		add_item(-1, 0);
		add_item(0, 1);
		write_k(1);
		add_item(VALUE_MIN, 1);
		add_item(0, 0);
		add_item(VALUE_MAX, 0);
		add_item(3, 1);
		write_k(2);
		add_item(-1, 0);
		add_item(-1, 0);
		add_item(-1, 1);
		write_k(64);
		add_item(VALUE_MAX, 1);

		// Full store: largest and smallest possible sums, and replacement
		// of the largest kept value by falling input.
		write_k(64);
		queue_set(70, MIX_ALL_MAX);
		queue_set(66, MIX_ALL_MIN);
		queue_set(72, MIX_FALLING);

		// Random phases over several settings of k.
		run_phase(3, 1'b0, 1'b1);
		run_phase(127, 1'b1, 1'b0);
		run_phase(65, 1'b0, 1'b0);
		run_phase(0, 1'b0, 1'b0);
		run_phase(1, 1'b0, 1'b1);
		run_phase(40, 1'b0, 1'b0);
		run_phase(count_t'($urandom_range(0, 127)), 1'b0, 1'b0);
		run_phase(64, 1'b1, 1'b0);

		wait_drained();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
